[sv/cbrb_pkg.sv]
`default_nettype none
package cbrb_pkg;

	// Storage depth in bytes; offsets and sizes are 13 bits wide.
	localparam int DEPTH  = 4096;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = 13;
	localparam int CMD_W  = 3;
	localparam int BYTE_W = 8;
	localparam int STAT_W = 2;

	// Input tdata layout, lowest bit first.
	localparam int IN_CMD_LSB  = 0;
	localparam int IN_LEN_LSB  = IN_CMD_LSB + CMD_W;
	localparam int IN_DIN_LSB  = IN_LEN_LSB + LEN_W;
	localparam int IN_BITS     = IN_DIN_LSB + BYTE_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

	// Output tdata layout, lowest bit first.
	localparam int OUT_STAT_LSB = 0;
	localparam int OUT_DOUT_LSB = OUT_STAT_LSB + STAT_W;
	localparam int OUT_CNT_LSB  = OUT_DOUT_LSB + BYTE_W;
	localparam int OUT_RAV_LSB  = OUT_CNT_LSB + LEN_W;
	localparam int OUT_WAV_LSB  = OUT_RAV_LSB + LEN_W;
	localparam int OUT_WRAP_LSB = OUT_WAV_LSB + LEN_W;
	localparam int OUT_BITS     = OUT_WRAP_LSB + 1;
	localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_BUFFER_SIZE = 1'b0;
	localparam logic [LEN_W-1:0] SIZE_RESET = LEN_W'(DEPTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_RESERVE = 3'd0,
		CMD_WRITE   = 3'd1,
		CMD_READ    = 3'd2,
		CMD_SKIP    = 3'd3,
		CMD_REVERSE = 3'd4,
		CMD_CLEAR   = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_OVERRUN = 2'd3
	} status_t;

	typedef struct packed {
		logic [LEN_W-1:0] rd;
		logic [LEN_W-1:0] wr;
		logic [LEN_W-1:0] end_ofs;
		logic             wrapped;
		logic [LEN_W-1:0] old_end;
		logic             old_end_v;
	} ring_state_t;

	typedef struct packed {
		logic             ok;
		logic [LEN_W-1:0] grant;
		ring_state_t      st;
	} reserve_t;

	localparam ring_state_t RING_CLEAR = '{
		rd: '0, wr: '0, end_ofs: '0, wrapped: 1'b0, old_end: '0, old_end_v: 1'b0
	};

endpackage
`default_nettype wire

[sv/contiguous_block_ring_buffer.sv]
`default_nettype none
// Contiguous-block byte ring. Each input item carries one command (reserve a
// contiguous block, write a byte, read a byte, skip forward, reverse back or
// clear) and produces exactly one result item with a status, the byte read,
// a count and the readable and writable totals after the command. The block
// takes one item per clock cycle while results are taken; each item passes
// the input register, then the result register (with the byte store read
// registered alongside the result) before its result is offered on m_tvalid.
// The byte store is a single-port-per-direction memory of 4096 bytes; its
// contents are undefined until written, so reading a never-written byte
// returns an arbitrary value. buffer_size sits at APB byte address 0;
// writing it clears the ring. Only pwdata[12:0] is used: zero is taken as
// one and values above 4096 as 4096. Write it only while the block is
// idle.
module contiguous_block_ring_buffer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// tdata: command[2:0], length[15:3], data_in[23:16]
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [cbrb_pkg::IN_TDATA_W-1:0]  s_tdata,
	// tdata: status[1:0], data_out[9:2], count[22:10], read_available[35:23],
	//        write_available[48:36], is_wrapped[49]
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [cbrb_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [cbrb_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [cbrb_pkg::PDATA_W-1:0]     pwdata,
	output logic [cbrb_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready
);

	localparam int LW = cbrb_pkg::LEN_W;
	localparam int AW = cbrb_pkg::ADDR_W;
	localparam logic [LW-1:0] DEPTH_L = LW'(cbrb_pkg::DEPTH);

	// ---- offset helpers ----------------------------------------------------

	function automatic logic [LW-1:0] sub0(input logic [LW-1:0] a, input logic [LW-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

	function automatic logic [LW-1:0] contig_read(input cbrb_pkg::ring_state_t s);
		return s.wrapped ? sub0(s.end_ofs, s.rd) : sub0(s.wr, s.rd);
	endfunction

	function automatic logic [LW-1:0] total_read(input cbrb_pkg::ring_state_t s);
		return s.wrapped ? LW'(sub0(s.end_ofs, s.rd) + s.wr) : sub0(s.wr, s.rd);
	endfunction

	function automatic logic [LW-1:0] contig_write(input cbrb_pkg::ring_state_t s,
			input logic [LW-1:0] size);
		return s.wrapped ? sub0(s.rd, s.wr) : sub0(size, s.wr);
	endfunction

	function automatic logic [LW-1:0] total_write(input cbrb_pkg::ring_state_t s,
			input logic [LW-1:0] size);
		return s.wrapped ? sub0(s.rd, s.wr) : LW'(sub0(size, s.wr) + s.rd);
	endfunction

	// Reader has reached the end mark: restart at the bottom and remember it.
	function automatic cbrb_pkg::ring_state_t unwrap_read(input cbrb_pkg::ring_state_t s);
		cbrb_pkg::ring_state_t r;
		r           = s;
		r.rd        = '0;
		r.old_end   = s.end_ofs;
		r.old_end_v = 1'b1;
		r.wrapped   = 1'b0;
		return r;
	endfunction

	function automatic cbrb_pkg::ring_state_t advance_read(input cbrb_pkg::ring_state_t s,
			input logic [LW-1:0] n);
		cbrb_pkg::ring_state_t r;
		r    = s;
		r.rd = LW'(s.rd + n);
		if (r.wrapped && r.rd == r.end_ofs) begin
			r = unwrap_read(r);
		end
		return r;
	endfunction

	// Writer jumps back to the bottom and leaves an end mark behind.
	function automatic cbrb_pkg::ring_state_t wrap_write(input cbrb_pkg::ring_state_t s);
		cbrb_pkg::ring_state_t r;
		r           = s;
		r.end_ofs   = s.wr;
		r.wr        = '0;
		r.wrapped   = 1'b1;
		r.old_end_v = 1'b0;
		return r;
	endfunction

	function automatic cbrb_pkg::reserve_t reserve_block(input cbrb_pkg::ring_state_t s,
			input logic [LW-1:0] len, input logic [LW-1:0] size);
		cbrb_pkg::reserve_t r;
		logic [LW-1:0] avail;
		avail   = contig_write(s, size);
		r.ok    = 1'b1;
		r.grant = avail;
		r.st    = s;
		if (avail < len) begin
			if (s.wrapped || s.rd < len) begin
				r.ok    = 1'b0;
				r.grant = '0;
			end else begin
				r.st    = wrap_write(s);
				r.grant = s.rd;
			end
		end
		return r;
	endfunction

	// ---- registers ---------------------------------------------------------

	logic                      valid_s1;
	logic [cbrb_pkg::CMD_W-1:0]  cmd_s1;
	logic [LW-1:0]             len_s1;
	logic [cbrb_pkg::BYTE_W-1:0] din_s1;

	cbrb_pkg::ring_state_t     ring_q;
	logic [LW-1:0]             size_q;

	logic                      valid_s2;
	cbrb_pkg::status_t         status_s2;
	logic [LW-1:0]             count_s2;
	logic [LW-1:0]             ravail_s2;
	logic [LW-1:0]             wavail_s2;
	logic                      wrap_s2;
	logic                      rd_ok_s2;
	logic [cbrb_pkg::BYTE_W-1:0] rdata_s2;

	logic [cbrb_pkg::BYTE_W-1:0] store_q [cbrb_pkg::DEPTH];

	// ---- handshakes --------------------------------------------------------

	logic adv_s2;
	logic fire_s1;
	logic cfg_wr;
	logic [LW-1:0] cfg_val;
	logic [LW-1:0] cfg_size;

	// Result register moves when empty or when its item is taken.
	assign adv_s2   = !valid_s2 || m_tready;
	assign fire_s1  = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready
		&& (paddr[2] == cbrb_pkg::REG_BUFFER_SIZE);
	assign cfg_val = pwdata[LW-1:0];

	always_comb begin
		// Saturate the written size into 1..DEPTH.
		if (cfg_val == '0) begin
			cfg_size = LW'(1);
		end else if (cfg_val > DEPTH_L) begin
			cfg_size = DEPTH_L;
		end else begin
			cfg_size = cfg_val;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == cbrb_pkg::REG_BUFFER_SIZE) begin
			prdata = cbrb_pkg::PDATA_W'(size_q);
		end
	end

	// ---- command step ------------------------------------------------------

	cbrb_pkg::ring_state_t nxt;
	cbrb_pkg::ring_state_t tmp;
	cbrb_pkg::reserve_t    res;
	cbrb_pkg::status_t     status_c;
	logic [LW-1:0]         count_c;
	logic [LW-1:0]         sz_c;
	logic [LW:0]           rpos_c;
	logic                  wr_en_c;
	logic                  rd_en_c;
	logic [AW-1:0]         waddr_c;
	logic [AW-1:0]         raddr_c;

	always_comb begin
		nxt      = ring_q;
		tmp      = ring_q;
		res      = reserve_block(ring_q, len_s1, size_q);
		status_c = cbrb_pkg::ST_OK;
		count_c  = '0;
		sz_c     = contig_read(ring_q);
		rpos_c   = '0;
		wr_en_c  = 1'b0;
		rd_en_c  = 1'b0;
		waddr_c  = ring_q.wr[AW-1:0];
		raddr_c  = ring_q.rd[AW-1:0];
		unique case (cbrb_pkg::cmd_t'(cmd_s1))
			cbrb_pkg::CMD_RESERVE: begin
				if (!res.ok) begin
					status_c = cbrb_pkg::ST_NOSPACE;
				end else begin
					count_c = res.grant;
					nxt     = res.st;
				end
			end
			cbrb_pkg::CMD_WRITE: begin
				// A single-byte reserve may wrap the writer first.
				res = reserve_block(ring_q, LW'(1), size_q);
				if (!res.ok) begin
					status_c = cbrb_pkg::ST_OVERRUN;
				end else if (res.st.wr >= DEPTH_L) begin
					status_c = cbrb_pkg::ST_OVERRUN;
					nxt      = res.st;
				end else begin
					wr_en_c = 1'b1;
					waddr_c = res.st.wr[AW-1:0];
					nxt     = res.st;
					nxt.wr  = LW'(res.st.wr + LW'(1));
					if (nxt.wr >= size_q) begin
						nxt = wrap_write(nxt);
					end
				end
			end
			cbrb_pkg::CMD_READ: begin
				// Consume an end mark with nothing left before it.
				if (contig_read(ring_q) == '0 && ring_q.wrapped) begin
					tmp = unwrap_read(ring_q);
				end
				if (contig_read(tmp) == '0 || tmp.rd >= DEPTH_L) begin
					status_c = cbrb_pkg::ST_EMPTY;
					nxt      = tmp;
				end else begin
					rd_en_c = 1'b1;
					raddr_c = tmp.rd[AW-1:0];
					nxt     = advance_read(tmp, LW'(1));
				end
			end
			cbrb_pkg::CMD_SKIP: begin
				if (len_s1 <= total_read(ring_q)) begin
					if (len_s1 > sz_c) begin
						tmp = advance_read(ring_q, sz_c);
						nxt = advance_read(tmp, LW'(len_s1 - sz_c));
					end else begin
						nxt = advance_read(ring_q, len_s1);
					end
					count_c = len_s1;
				end
			end
			cbrb_pkg::CMD_REVERSE: begin
				if (!ring_q.wrapped && ring_q.old_end_v) begin
					rpos_c = {1'b0, ring_q.rd} + {1'b0, sub0(ring_q.old_end, ring_q.wr)};
				end else if (!ring_q.wrapped) begin
					rpos_c = {1'b0, ring_q.rd};
				end else begin
					rpos_c = {1'b0, sub0(ring_q.rd, ring_q.wr)};
				end
				if ({1'b0, len_s1} <= rpos_c) begin
					if (!ring_q.wrapped && len_s1 > ring_q.rd) begin
						// Back across the bottom: restore the old end mark.
						nxt.end_ofs   = ring_q.old_end;
						nxt.wrapped   = 1'b1;
						nxt.old_end_v = 1'b0;
						nxt.rd        = sub0(ring_q.old_end, LW'(len_s1 - ring_q.rd));
					end else begin
						nxt.rd = LW'(ring_q.rd - len_s1);
					end
					count_c = len_s1;
				end
			end
			cbrb_pkg::CMD_CLEAR: begin
				nxt = cbrb_pkg::RING_CLEAR;
			end
			default: begin
				// Unused codes: hold everything.
				nxt = ring_q;
			end
		endcase
	end

	// ---- state and pipeline registers --------------------------------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ring_q   <= cbrb_pkg::RING_CLEAR;
			size_q   <= cbrb_pkg::SIZE_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			// Size writes must arrive only while idle; the block does not enforce it. They empty the ring.
			if (cfg_wr) begin
				size_q <= cfg_size;
				ring_q <= cbrb_pkg::RING_CLEAR;
			end else if (fire_s1) begin
				ring_q <= nxt;
			end
		end
	end

	// Input register: hold the item until the step takes it.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tdata[cbrb_pkg::IN_CMD_LSB +: cbrb_pkg::CMD_W];
			len_s1 <= s_tdata[cbrb_pkg::IN_LEN_LSB +: LW];
			din_s1 <= s_tdata[cbrb_pkg::IN_DIN_LSB +: cbrb_pkg::BYTE_W];
		end
	end

	// Result register: capture the step outcome and totals after it.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_s2 <= status_c;
			count_s2  <= count_c;
			ravail_s2 <= total_read(nxt);
			wavail_s2 <= total_write(nxt, size_q);
			wrap_s2   <= nxt.wrapped;
			rd_ok_s2  <= rd_en_c;
		end
	end

	// Byte store: at most one write and one registered read per cycle, only when a step fires.
	always_ff @(posedge clk) begin
		if (fire_s1 && wr_en_c) begin
			store_q[waddr_c] <= din_s1;
		end
		if (fire_s1 && rd_en_c) begin
			rdata_s2 <= store_q[raddr_c];
		end
	end

	assign m_tvalid = valid_s2;

	always_comb begin
		m_tdata = '0;
		m_tdata[cbrb_pkg::OUT_STAT_LSB +: cbrb_pkg::STAT_W] = status_s2;
		m_tdata[cbrb_pkg::OUT_DOUT_LSB +: cbrb_pkg::BYTE_W] = rd_ok_s2 ? rdata_s2 : '0;
		m_tdata[cbrb_pkg::OUT_CNT_LSB +: LW]  = count_s2;
		m_tdata[cbrb_pkg::OUT_RAV_LSB +: LW]  = ravail_s2;
		m_tdata[cbrb_pkg::OUT_WAV_LSB +: LW]  = wavail_s2;
		m_tdata[cbrb_pkg::OUT_WRAP_LSB]       = wrap_s2;
	end

endmodule
`default_nettype wire

[sv/cbrb_checker.sv]
`default_nettype none
module cbrb_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [cbrb_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic [cbrb_pkg::STAT_W-1:0] status;
	logic [cbrb_pkg::BYTE_W-1:0] data_out;
	logic [cbrb_pkg::LEN_W-1:0]  count;
	logic [cbrb_pkg::LEN_W-1:0]  read_available;
	logic [cbrb_pkg::LEN_W-1:0]  write_available;
	logic                        is_wrapped;

	assign status          = m_tdata[cbrb_pkg::OUT_STAT_LSB +: cbrb_pkg::STAT_W];
	assign data_out        = m_tdata[cbrb_pkg::OUT_DOUT_LSB +: cbrb_pkg::BYTE_W];
	assign count           = m_tdata[cbrb_pkg::OUT_CNT_LSB +: cbrb_pkg::LEN_W];
	assign read_available  = m_tdata[cbrb_pkg::OUT_RAV_LSB +: cbrb_pkg::LEN_W];
	assign write_available = m_tdata[cbrb_pkg::OUT_WAV_LSB +: cbrb_pkg::LEN_W];
	assign is_wrapped      = m_tdata[cbrb_pkg::OUT_WRAP_LSB];

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An empty read leaves nothing readable and no end mark.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == cbrb_pkg::ST_EMPTY |->
			read_available == '0 && !is_wrapped && data_out == '0)
		else $error("empty read with data still readable");

	// A refused write means the ring had no free byte at all.
	a_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == cbrb_pkg::ST_OVERRUN |->
			write_available == '0 && count == '0 && data_out == '0)
		else $error("write refused with space free");

	// A failed reserve grants nothing.
	a_nospace: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == cbrb_pkg::ST_NOSPACE |-> count == '0 && data_out == '0)
		else $error("failed reserve reported a grant");

endmodule

bind contiguous_block_ring_buffer cbrb_checker u_cbrb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

[bench/contiguous_block_ring_buffer_tb.sv]
`timescale 1ns / 100ps

module contiguous_block_ring_buffer_tb;

	localparam int DEPTH        = cbrb_pkg::DEPTH;
	localparam int ADDR_W       = cbrb_pkg::ADDR_W;
	localparam int CMD_W        = cbrb_pkg::CMD_W;
	localparam int LEN_W        = cbrb_pkg::LEN_W;
	localparam int BYTE_W       = cbrb_pkg::BYTE_W;
	localparam int STAT_W       = cbrb_pkg::STAT_W;
	localparam int IN_TDATA_W   = cbrb_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W  = cbrb_pkg::OUT_TDATA_W;
	localparam int OUT_STAT_LSB = cbrb_pkg::OUT_STAT_LSB;
	localparam int OUT_DOUT_LSB = cbrb_pkg::OUT_DOUT_LSB;
	localparam int OUT_CNT_LSB  = cbrb_pkg::OUT_CNT_LSB;
	localparam int OUT_RAV_LSB  = cbrb_pkg::OUT_RAV_LSB;
	localparam int OUT_WAV_LSB  = cbrb_pkg::OUT_WAV_LSB;
	localparam int OUT_WRAP_LSB = cbrb_pkg::OUT_WRAP_LSB;
	localparam int PADDR_W      = cbrb_pkg::PADDR_W;
	localparam int PDATA_W      = cbrb_pkg::PDATA_W;

	// Spare command codes: the block must treat them as no-ops.
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	// buffer_size is register 0, so it sits at byte address 0.
	localparam logic [PADDR_W-1:0] ADDR_BUFFER_SIZE = '0;

	localparam int RANDOM_PHASES  = 9;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 6;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] din;
	} ring_cmd_t;

	typedef struct packed {
		cbrb_pkg::status_t status;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  count;
		logic [LEN_W-1:0]  rd_avail;
		logic [LEN_W-1:0]  wr_avail;
		logic              wrapped;
	} ring_result_t;

	typedef struct {
		ring_cmd_t    c;
		bit           typed;
		ring_result_t want;
	} ring_row_t;

	// Results that can be read straight off an empty 4096-byte ring.
	localparam ring_result_t EMPTY_READ  =
		'{cbrb_pkg::ST_EMPTY, 8'd0, 13'd0, 13'd0, 13'd4096, 1'b0};
	localparam ring_result_t EMPTY_NOP   =
		'{cbrb_pkg::ST_OK, 8'd0, 13'd0, 13'd0, 13'd4096, 1'b0};
	localparam ring_result_t WHOLE_GRANT =
		'{cbrb_pkg::ST_OK, 8'd0, 13'd4096, 13'd0, 13'd4096, 1'b0};
	localparam ring_result_t NO_ROOM     =
		'{cbrb_pkg::ST_NOSPACE, 8'd0, 13'd0, 13'd0, 13'd4096, 1'b0};
	localparam ring_result_t UNTYPED     = '0;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [PDATA_W-1:0]     pwdata;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	// Shadow of the ring: offsets, end marks and the byte store.
	logic [LEN_W-1:0]  ring_size;
	logic [LEN_W-1:0]  rd_ofs;
	logic [LEN_W-1:0]  wr_ofs;
	logic [LEN_W-1:0]  end_ofs;
	logic              ring_wrapped;
	logic [LEN_W-1:0]  old_end;
	logic              old_end_ok;
	logic [BYTE_W-1:0] byte_mem [DEPTH];
	bit                byte_written [DEPTH];

	ring_result_t results_due [$];
	ring_row_t    directed_rows [$];

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_req;
	int  mismatches;
	int  items_sent;
	int  results_checked;
	int  sizes_written;

	contiguous_block_ring_buffer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Ring predictor
	// ---------------------------------------------------------------------

	function automatic logic [LEN_W-1:0] floor_sub(input logic [LEN_W-1:0] a,
			input logic [LEN_W-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	function automatic logic [LEN_W-1:0] contig_readable();
		return ring_wrapped ? floor_sub(end_ofs, rd_ofs) : floor_sub(wr_ofs, rd_ofs);
	endfunction

	// Readable bytes including the part that wrapped round to the start.
	function automatic logic [LEN_W-1:0] total_readable();
		return ring_wrapped ? floor_sub(end_ofs, rd_ofs) + wr_ofs
			: floor_sub(wr_ofs, rd_ofs);
	endfunction

	function automatic logic [LEN_W-1:0] contig_writable();
		return ring_wrapped ? floor_sub(rd_ofs, wr_ofs) : floor_sub(ring_size, wr_ofs);
	endfunction

	function automatic logic [LEN_W-1:0] total_writable();
		return ring_wrapped ? floor_sub(rd_ofs, wr_ofs)
			: floor_sub(ring_size, wr_ofs) + rd_ofs;
	endfunction

	function automatic void clear_ring();
		rd_ofs       = '0;
		wr_ofs       = '0;
		end_ofs      = '0;
		ring_wrapped = 1'b0;
		old_end      = '0;
		old_end_ok   = 1'b0;
	endfunction

	// Reader hits the end mark: restart at 0 but keep the mark for reverse.
	function automatic void unwrap_reader();
		rd_ofs       = '0;
		old_end      = end_ofs;
		old_end_ok   = 1'b1;
		ring_wrapped = 1'b0;
	endfunction

	function automatic void advance_reader(input logic [LEN_W-1:0] n);
		rd_ofs = rd_ofs + n;
		if (ring_wrapped && rd_ofs == end_ofs)
			unwrap_reader();
	endfunction

	function automatic void wrap_writer();
		end_ofs      = wr_ofs;
		wr_ofs       = '0;
		ring_wrapped = 1'b1;
		old_end_ok   = 1'b0;
	endfunction

	// Fit a block at the tail, or wrap early to the start, or refuse.
	function automatic bit try_reserve(input logic [LEN_W-1:0] len,
			output logic [LEN_W-1:0] grant);
		logic [LEN_W-1:0] room;
		room  = contig_writable();
		grant = '0;
		if (room >= len) begin
			grant = room;
			return 1'b1;
		end
		if (ring_wrapped || rd_ofs < len)
			return 1'b0;
		wrap_writer();
		grant = rd_ofs;
		return 1'b1;
	endfunction

	function automatic logic [LEN_W-1:0] clamp_size(input logic [LEN_W-1:0] v);
		if (v == 0)
			return 13'd1;
		if (v > DEPTH)
			return LEN_W'(DEPTH);
		return v;
	endfunction

	// Guard for the stimulus: a read must never land on a byte never written.
	function automatic bit read_reaches_unwritten();
		logic [LEN_W-1:0] pos;
		bit               has_data;
		if (ring_wrapped && contig_readable() == 0) begin
			pos      = '0;
			has_data = (wr_ofs != 0);
		end else begin
			pos      = rd_ofs;
			has_data = (contig_readable() != 0);
		end
		return has_data && pos < DEPTH && !byte_written[pos[ADDR_W-1:0]];
	endfunction

	function automatic ring_result_t predict_ring_result(input ring_cmd_t c);
		ring_result_t     r;
		logic [LEN_W-1:0] grant;
		logic [LEN_W-1:0] run;
		logic [LEN_W-1:0] room_back;
		bit               ok;
		r = '0;
		r.status = cbrb_pkg::ST_OK;
		case (c.cmd)
			cbrb_pkg::CMD_RESERVE: begin
				if (try_reserve(c.len, grant))
					r.count = grant;
				else
					r.status = cbrb_pkg::ST_NOSPACE;
			end
			cbrb_pkg::CMD_WRITE: begin
				ok = try_reserve(13'd1, grant);
				if (!ok || wr_ofs >= DEPTH) begin
					r.status = cbrb_pkg::ST_OVERRUN;
				end else begin
					byte_mem[wr_ofs[ADDR_W-1:0]]     = c.din;
					byte_written[wr_ofs[ADDR_W-1:0]] = 1'b1;
					wr_ofs = wr_ofs + 1'b1;
					if (wr_ofs >= ring_size)
						wrap_writer();
				end
			end
			cbrb_pkg::CMD_READ: begin
				// An end mark with nothing before it is consumed even by an empty read.
				if (contig_readable() == 0 && ring_wrapped)
					unwrap_reader();
				if (contig_readable() == 0 || rd_ofs >= DEPTH) begin
					r.status = cbrb_pkg::ST_EMPTY;
				end else begin
					r.data = byte_mem[rd_ofs[ADDR_W-1:0]];
					advance_reader(13'd1);
				end
			end
			cbrb_pkg::CMD_SKIP: begin
				run = contig_readable();
				if (c.len <= total_readable()) begin
					if (c.len > run) begin
						advance_reader(run);
						advance_reader(c.len - run);
					end else begin
						advance_reader(c.len);
					end
					r.count = c.len;
				end
			end
			cbrb_pkg::CMD_REVERSE: begin
				// Clamp the part of the old end mark past the writer at zero.
				if (!ring_wrapped && old_end_ok)
					room_back = rd_ofs + floor_sub(old_end, wr_ofs);
				else if (!ring_wrapped)
					room_back = rd_ofs;
				else
					room_back = floor_sub(rd_ofs, wr_ofs);
				if (c.len <= room_back) begin
					if (!ring_wrapped && c.len > rd_ofs) begin
						run          = c.len - rd_ofs;
						end_ofs      = old_end;
						ring_wrapped = 1'b1;
						old_end_ok   = 1'b0;
						rd_ofs       = floor_sub(end_ofs, run);
					end else begin
						rd_ofs = rd_ofs - c.len;
					end
					r.count = c.len;
				end
			end
			cbrb_pkg::CMD_CLEAR: clear_ring();
			default: ;
		endcase
		r.rd_avail = total_readable();
		r.wr_avail = total_writable();
		r.wrapped  = ring_wrapped;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------

	// Offer one item from a falling edge; predict it once it is taken.
	task automatic send_item(input ring_cmd_t c, input bit typed, input ring_result_t want);
		ring_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata  = IN_TDATA_W'({c.din, c.len, c.cmd});
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = predict_ring_result(c);
		// Typed rows still advance the shadow state; their own value is checked.
		results_due.push_back(typed ? want : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Register write: setup, then access until pready.
	task automatic write_ring_size(input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		paddr   = ADDR_BUFFER_SIZE;
		pwdata  = value;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		ring_size = clamp_size(value[LEN_W-1:0]);
		clear_ring();
		sizes_written++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Hold until every predicted result has come back, then let the pipe settle.
	task automatic drain_results();
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len,
			input logic [BYTE_W-1:0] din, input bit typed, input ring_result_t want);
		ring_row_t row;
		row.c.cmd = cmd;
		row.c.len = len;
		row.c.din = din;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	// ---------------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------------

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		$display("MISMATCH at result %0d, %s: got %0d, expected %0d",
			results_checked, field, got, want);
		mismatches++;
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			m_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare every result taken at a rising edge with the oldest prediction.
	always @(posedge clk) begin
		ring_result_t want;
		ring_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want         = results_due.pop_front();
				got.status   = cbrb_pkg::status_t'(m_tdata[OUT_STAT_LSB +: STAT_W]);
				got.data     = m_tdata[OUT_DOUT_LSB +: BYTE_W];
				got.count    = m_tdata[OUT_CNT_LSB +: LEN_W];
				got.rd_avail = m_tdata[OUT_RAV_LSB +: LEN_W];
				got.wr_avail = m_tdata[OUT_WAV_LSB +: LEN_W];
				got.wrapped  = m_tdata[OUT_WRAP_LSB];
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.data !== want.data)
					report_mismatch("data_out", 32'(got.data), 32'(want.data));
				if (got.count !== want.count)
					report_mismatch("count", 32'(got.count), 32'(want.count));
				if (got.rd_avail !== want.rd_avail)
					report_mismatch("read_available", 32'(got.rd_avail),
						32'(want.rd_avail));
				if (got.wr_avail !== want.wr_avail)
					report_mismatch("write_available", 32'(got.wr_avail),
						32'(want.wr_avail));
				if (got.wrapped !== want.wrapped)
					report_mismatch("is_wrapped", 32'(got.wrapped), 32'(want.wrapped));
				results_checked++;
			end
		end
	end

	// Give up well past the slowest correct run.
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------

	initial begin
		ring_cmd_t        c;
		int               burst;
		int               pick;
		logic [PDATA_W-1:0] phase_size [RANDOM_PHASES];

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		hold_req = 1'b0;
		mismatches      = 0;
		items_sent      = 0;
		results_checked = 0;
		sizes_written   = 0;
		burst           = 0;
		send_idle_pct   = 12;
		recv_idle_pct   = 88;
		ring_size = cbrb_pkg::SIZE_RESET;
		clear_ring();

		// Register values per phase: zero and the 13-bit maximum test saturation,
		// and the high bits of one write must be ignored.
		phase_size = '{32'h0000_0000, 32'd5, 32'h0000_1FFF, 32'd2, 32'd16,
			32'hFFFF_E025, 32'd8, 32'd1, 32'd4096};

		// Directed rows on the 4096-byte ring left by reset.
		add_row(cbrb_pkg::CMD_READ,    13'd0,    8'h00, 1'b1, EMPTY_READ);
		add_row(cbrb_pkg::CMD_RESERVE, 13'd4096, 8'h00, 1'b1, WHOLE_GRANT);
		add_row(cbrb_pkg::CMD_RESERVE, 13'd8191, 8'hFF, 1'b1, NO_ROOM);
		add_row(cbrb_pkg::CMD_RESERVE, 13'd0,    8'h00, 1'b1, WHOLE_GRANT);
		add_row(cbrb_pkg::CMD_SKIP,    13'd0,    8'h00, 1'b1, EMPTY_NOP);
		add_row(cbrb_pkg::CMD_SKIP,    13'd1,    8'h00, 1'b1, EMPTY_NOP);
		add_row(cbrb_pkg::CMD_REVERSE, 13'd1,    8'h00, 1'b1, EMPTY_NOP);
		add_row(cbrb_pkg::CMD_WRITE,   13'd0,    8'h00, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_WRITE,   13'd4096, 8'hFF, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_WRITE,   13'd8191, 8'hA5, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_READ,    13'd0,    8'h00, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_READ,    13'd8191, 8'hFF, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_REVERSE, 13'd2,    8'h00, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_SKIP,    13'd4096, 8'h00, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_SKIP,    13'd2,    8'h00, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_READ,    13'd0,    8'h00, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_READ,    13'd0,    8'h00, 1'b0, UNTYPED);
		add_row(CMD_SPARE_6,           13'd8191, 8'hFF, 1'b1, EMPTY_NOP);
		add_row(CMD_SPARE_7,           13'd4096, 8'h5A, 1'b1, EMPTY_NOP);
		add_row(cbrb_pkg::CMD_CLEAR,   13'd8191, 8'hFF, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_READ,    13'd0,    8'h00, 1'b1, EMPTY_READ);
		add_row(cbrb_pkg::CMD_WRITE,   13'd8191, 8'h5A, 1'b0, UNTYPED);
		add_row(cbrb_pkg::CMD_READ,    13'd0,    8'h00, 1'b0, UNTYPED);

		// Hold reset, then release it on a falling edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
		s_tvalid = 1'b0;
		drain_results();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			// Receiver-heavy idling, then sender-heavy, then none at all.
			case (p / 3)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 12;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_ring_size(phase_size[p]);
			// Stall the output for a long stretch so the input backs up.
			if (p == 6)
				hold_req = 1'b1;
			burst = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				c.din = BYTE_W'($urandom_range(255));
				c.len = LEN_W'($urandom_range(8191));
				if (burst > 0) begin
					// Fill the block just reserved.
					c.cmd = cbrb_pkg::CMD_WRITE;
					burst--;
				end else begin
					pick = $urandom_range(99);
					if (pick < 10) begin
						c.cmd = cbrb_pkg::CMD_RESERVE;
						if ($urandom_range(7) != 0)
							c.len = LEN_W'($urandom_range(ring_size + 1));
						burst = (c.len > 13'd12) ? 12 : int'(c.len);
					end else if (pick < 45) begin
						c.cmd = cbrb_pkg::CMD_WRITE;
					end else if (pick < 75) begin
						c.cmd = cbrb_pkg::CMD_READ;
					end else if (pick < 84) begin
						c.cmd = cbrb_pkg::CMD_SKIP;
						case ($urandom_range(3))
							0, 1: c.len = LEN_W'($urandom_range(3));
							2: c.len = total_readable();
							default: ;
						endcase
					end else if (pick < 93) begin
						c.cmd = cbrb_pkg::CMD_REVERSE;
						case ($urandom_range(3))
							0, 1: c.len = LEN_W'($urandom_range(3));
							2: c.len = LEN_W'($urandom_range(ring_size));
							default: ;
						endcase
					end else if (pick < 96) begin
						c.cmd = cbrb_pkg::CMD_CLEAR;
					end else begin
						c.cmd = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
					end
				end
				// Never read a byte the store has not been given.
				if (c.cmd == cbrb_pkg::CMD_READ && read_reaches_unwritten())
					c.cmd = cbrb_pkg::CMD_WRITE;
				send_item(c, 1'b0, UNTYPED);
			end
			s_tvalid = 1'b0;
			drain_results();
		end

		$display("Run drove %0d items through %0d ring sizes (1 to 4096 bytes), every command",
			items_sent, sizes_written + 1);
		$display("and spare code, %0d results checked, with a %0d-cycle output stall.",
			results_checked, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/cbrb_pkg.sv
sv/contiguous_block_ring_buffer.sv
sv/cbrb_checker.sv
bench/contiguous_block_ring_buffer_tb.sv
